// ===== hdl/tst_pkg.sv =====
// Shared sizes, codes, entry type and sort key function of the two-key sorted table.
package tst_pkg;

	localparam int TABLE_DEPTH = 32;
	localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

	localparam int VALUE_W     = 8;
	localparam int PRIO_W      = 4;
	localparam int KEY_W       = VALUE_W + PRIO_W;
	localparam int RCOUNT_W    = 6;

	localparam int PADDR_W     = 3;
	localparam int PDATA_W     = 32;
	localparam int REG_IDX_W   = PADDR_W - 2;
	localparam logic [REG_IDX_W-1:0] REG_KEY_ORDER = REG_IDX_W'(0);

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_DELETE = 2'd1,
		OP_DUMP   = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE       = 2'd0,
		ST_FULL       = 2'd1,
		ST_DUMP_ENTRY = 2'd2,
		ST_DUMP_EMPTY = 2'd3
	} status_t;

	typedef struct packed {
		logic [VALUE_W-1:0] val;
		logic [PRIO_W-1:0]  prio;
	} entry_t;

	// Order 0: priority is the major field; order 1: value is the major field.
	function automatic logic [KEY_W-1:0] make_key(input logic order, input entry_t e);
		logic [KEY_W-1:0] k;
		if (order) begin
			k = {e.val, e.prio};
		end else begin
			k = {e.prio, e.val};
		end
		return k;
	endfunction

endpackage

// ===== hdl/tst_ifs.sv =====
// Command and response channel interfaces of the two-key sorted table.
interface tst_cmd_if;
	logic                         valid;
	logic                         ready;
	logic [1:0]                   op;
	logic [tst_pkg::VALUE_W-1:0]  item_value;
	logic [tst_pkg::PRIO_W-1:0]   item_priority;

	modport source (output valid, output op, output item_value, output item_priority,
		input ready);
	modport sink (input valid, input op, input item_value, input item_priority,
		output ready);
endinterface

interface tst_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [1:0]                   status;
	logic [tst_pkg::VALUE_W-1:0]  out_value;
	logic [tst_pkg::PRIO_W-1:0]   out_priority;
	logic [tst_pkg::RCOUNT_W-1:0] removed_count;
	logic                         last;

	modport source (output valid, output status, output out_value, output out_priority,
		output removed_count, output last, input ready);
	modport sink (input valid, input status, input out_value, input out_priority,
		input removed_count, input last, output ready);
endinterface

// ===== hdl/two_key_sorted_table_unit.sv =====
// Top level of the two-key sorted table: sequencer, entry memory, response register, APB.
//
// The unit keeps up to TABLE_DEPTH (value, priority) entries in sorted order in a single-port
// style memory (one write and one registered read per cycle) and works on one command word
// at a time; cmd.ready is high only while the sequencer is idle. Every entry visit reads the
// memory in one state and uses the registered read data in the next. An insert scans for
// its place, moves each entry above it up by one to open the gap, writes the new entry and
// then issues the response; a delete visits every entry and compacts the survivors; a dump
// issues one response word per stored entry and waits while the response register is full.
// A full-table insert, an empty dump and an unused op go straight to the response. The
// key_order register (APB byte address 0, bit 0) chooses priority-then-value (0) or
// value-then-priority (1); changing it does not re-sort what is stored. Inserts go in
// front of the first entry whose key is not below their own, so equal keys go first.
// A response word waiting in the output register does not stop the next command from being
// accepted. Configure only while the unit is idle.
module two_key_sorted_table_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	tst_cmd_if.sink                       cmd,
	tst_rsp_if.source                     rsp,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [tst_pkg::PADDR_W-1:0]   paddr,
	input  logic [tst_pkg::PDATA_W-1:0]   pwdata,
	output logic [tst_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready
);

	typedef enum logic [10:0] {
		S_IDLE     = 11'b000_0000_0001,
		S_SCAN_RD  = 11'b000_0000_0010,
		S_SCAN_CMP = 11'b000_0000_0100,
		S_SHIFT_RD = 11'b000_0000_1000,
		S_SHIFT_WR = 11'b000_0001_0000,
		S_INS_WR   = 11'b000_0010_0000,
		S_DEL_RD   = 11'b000_0100_0000,
		S_DEL_CHK  = 11'b000_1000_0000,
		S_DUMP_RD  = 11'b001_0000_0000,
		S_DUMP_OUT = 11'b010_0000_0000,
		S_RESP     = 11'b100_0000_0000
	} state_t;

	state_t                         state_q;

	// Entry memory and its registered read port.
	tst_pkg::entry_t                mem_q [tst_pkg::TABLE_DEPTH];
	tst_pkg::entry_t                rd_data_q;
	logic [tst_pkg::IDX_W-1:0]      rd_addr;
	logic                           mem_we;
	logic [tst_pkg::IDX_W-1:0]      mem_wa;
	tst_pkg::entry_t                mem_wd;

	// Sequencer registers.
	logic [tst_pkg::CNT_W-1:0]      count_q;
	logic [tst_pkg::CNT_W-1:0]      idx_q;
	logic [tst_pkg::CNT_W-1:0]      wr_q;
	logic [tst_pkg::CNT_W-1:0]      removed_q;
	logic [tst_pkg::IDX_W-1:0]      pos_q;
	logic [tst_pkg::IDX_W-1:0]      sidx_q;
	tst_pkg::entry_t                item_q;
	tst_pkg::status_t               stat_q;

	// Configuration.
	logic                           key_order_q;
	logic                           cfg_sel;

	// Response register.
	logic                           rsp_valid_q;
	tst_pkg::status_t               rsp_status_q;
	tst_pkg::entry_t                rsp_entry_q;
	logic [tst_pkg::RCOUNT_W-1:0]   rsp_removed_q;
	logic                           rsp_last_q;
	logic                           rsp_free;

	// Shared compare unit: key of the entry just read against the key being inserted.
	logic                           key_ge;
	logic                           dump_last;

	assign key_ge    = tst_pkg::make_key(key_order_q, rd_data_q)
		>= tst_pkg::make_key(key_order_q, item_q);
	assign dump_last = (idx_q + tst_pkg::CNT_W'(1)) == count_q;
	assign rsp_free  = !rsp_valid_q || rsp.ready;

	// ---------------------------------------------------------------- APB
	assign cfg_sel = (paddr[tst_pkg::PADDR_W-1:2] == tst_pkg::REG_KEY_ORDER);
	assign pready  = 1'b1;
	assign prdata  = cfg_sel ? tst_pkg::PDATA_W'(key_order_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_order_q <= 1'b0;
		end else if (psel && penable && pwrite && cfg_sel) begin
			key_order_q <= pwdata[0];
		end
	end

	// ---------------------------------------------------------------- memory
	// Shifting reads the entry below the gap; every other sweep reads at the scan index.
	always_comb begin
		case (state_q)
			S_SHIFT_RD, S_SHIFT_WR: rd_addr = sidx_q - tst_pkg::IDX_W'(1);
			default:                rd_addr = idx_q[tst_pkg::IDX_W-1:0];
		endcase
	end

	always_comb begin
		mem_we = 1'b0;
		mem_wa = sidx_q;
		mem_wd = rd_data_q;
		case (state_q)
			S_SHIFT_WR: begin
				mem_we = 1'b1;
			end
			S_INS_WR: begin
				mem_we = 1'b1;
				mem_wa = pos_q;
				mem_wd = item_q;
			end
			S_DEL_CHK: begin
				// Keep the survivor: compact it down to the write index.
				mem_we = (rd_data_q.val != item_q.val);
				mem_wa = wr_q[tst_pkg::IDX_W-1:0];
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_wa] <= mem_wd;
		end
	end

	always_ff @(posedge clk) begin
		rd_data_q <= mem_q[rd_addr];
	end

	// ---------------------------------------------------------------- sequencer
	assign cmd.ready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			idx_q     <= '0;
			wr_q      <= '0;
			removed_q <= '0;
			pos_q     <= '0;
			sidx_q    <= '0;
			stat_q    <= tst_pkg::ST_DONE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cmd.valid) begin
						idx_q     <= '0;
						wr_q      <= '0;
						removed_q <= '0;
						stat_q    <= tst_pkg::ST_DONE;
						case (cmd.op)
							tst_pkg::OP_INSERT: begin
								if (count_q == tst_pkg::CNT_W'(tst_pkg::TABLE_DEPTH)) begin
									stat_q  <= tst_pkg::ST_FULL;
									state_q <= S_RESP;
								end else begin
									state_q <= S_SCAN_RD;
								end
							end
							tst_pkg::OP_DELETE: begin
								state_q <= S_DEL_RD;
							end
							tst_pkg::OP_DUMP: begin
								if (count_q == '0) begin
									stat_q  <= tst_pkg::ST_DUMP_EMPTY;
									state_q <= S_RESP;
								end else begin
									state_q <= S_DUMP_RD;
								end
							end
							default: begin
								state_q <= S_RESP;
							end
						endcase
					end
				end
				S_SCAN_RD: begin
					if (idx_q == count_q) begin
						// Nothing at or above the new key: append at the end.
						pos_q   <= count_q[tst_pkg::IDX_W-1:0];
						sidx_q  <= count_q[tst_pkg::IDX_W-1:0];
						state_q <= S_SHIFT_RD;
					end else begin
						state_q <= S_SCAN_CMP;
					end
				end
				S_SCAN_CMP: begin
					if (key_ge) begin
						pos_q   <= idx_q[tst_pkg::IDX_W-1:0];
						sidx_q  <= count_q[tst_pkg::IDX_W-1:0];
						state_q <= S_SHIFT_RD;
					end else begin
						idx_q   <= idx_q + tst_pkg::CNT_W'(1);
						state_q <= S_SCAN_RD;
					end
				end
				S_SHIFT_RD: begin
					if (sidx_q == pos_q) begin
						state_q <= S_INS_WR;
					end else begin
						state_q <= S_SHIFT_WR;
					end
				end
				S_SHIFT_WR: begin
					sidx_q  <= sidx_q - tst_pkg::IDX_W'(1);
					state_q <= S_SHIFT_RD;
				end
				S_INS_WR: begin
					count_q <= count_q + tst_pkg::CNT_W'(1);
					state_q <= S_RESP;
				end
				S_DEL_RD: begin
					if (idx_q == count_q) begin
						count_q <= wr_q;
						state_q <= S_RESP;
					end else begin
						state_q <= S_DEL_CHK;
					end
				end
				S_DEL_CHK: begin
					if (rd_data_q.val == item_q.val) begin
						removed_q <= removed_q + tst_pkg::CNT_W'(1);
					end else begin
						wr_q <= wr_q + tst_pkg::CNT_W'(1);
					end
					idx_q   <= idx_q + tst_pkg::CNT_W'(1);
					state_q <= S_DEL_RD;
				end
				S_DUMP_RD: begin
					state_q <= S_DUMP_OUT;
				end
				S_DUMP_OUT: begin
					// Hold the read address until the response register frees up.
					if (rsp_free) begin
						if (dump_last) begin
							state_q <= S_IDLE;
						end else begin
							idx_q   <= idx_q + tst_pkg::CNT_W'(1);
							state_q <= S_DUMP_RD;
						end
					end
				end
				S_RESP: begin
					if (rsp_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Command payload is captured on accept; no reset needed.
	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			item_q.val  <= cmd.item_value;
			item_q.prio <= cmd.item_priority;
		end
	end

	// ---------------------------------------------------------------- response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_free) begin
			rsp_valid_q <= (state_q == S_DUMP_OUT) || (state_q == S_RESP);
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_free) begin
			if (state_q == S_DUMP_OUT) begin
				rsp_status_q  <= tst_pkg::ST_DUMP_ENTRY;
				rsp_entry_q   <= rd_data_q;
				rsp_removed_q <= '0;
				rsp_last_q    <= dump_last;
			end else if (state_q == S_RESP) begin
				rsp_status_q  <= stat_q;
				rsp_entry_q   <= '0;
				rsp_removed_q <= tst_pkg::RCOUNT_W'(removed_q);
				rsp_last_q    <= 1'b1;
			end
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.status        = rsp_status_q;
	assign rsp.out_value     = rsp_entry_q.val;
	assign rsp.out_priority  = rsp_entry_q.prio;
	assign rsp.removed_count = rsp_removed_q;
	assign rsp.last          = rsp_last_q;

	// ---------------------------------------------------------------- assertions
`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= tst_pkg::CNT_W'(tst_pkg::TABLE_DEPTH))
		else $error("entry count above table depth");

	a_shift_above_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SHIFT_WR) |-> (sidx_q > pos_q))
		else $error("gap shift moved below the insert position");

	a_compact_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DEL_CHK) |-> ((wr_q <= idx_q) && (idx_q < count_q)))
		else $error("delete compaction overran its read index");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_INS_WR) |=> (count_q == $past(count_q) + tst_pkg::CNT_W'(1)))
		else $error("insert did not grow the table by one");
`endif

endmodule
